@@ sv/lsdc_pkg.sv @@
package lsdc_pkg;

    localparam logic [7:0]  DEBOUNCE_COUNT_RESET = 8'd3;
    localparam logic [15:0] CONFIRM_DELAY_RESET  = 16'd10;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_DELAY  = 1'b1;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_WAIT = 2'd1,
        PHASE_DONE = 2'd2
    } lsdc_phase_t;

    typedef struct packed {
        logic up_raw;
        logic down_raw;
        logic sample_strobe;
        logic tick_strobe;
        logic clear_confirm;
    } lsdc_in_t;

    typedef struct packed {
        logic       up_level;
        logic       down_level;
        logic       up_pending;
        logic       down_pending;
        logic [1:0] confirm_phase;
        logic       confirm_busy;
    } lsdc_out_t;

    typedef struct packed {
        logic       level;
        logic [7:0] count;
        logic       rise;
    } lsdc_deb_t;

endpackage

@@ sv/limit_switch_debounce_confirm.sv @@
// A result is registered and shown in the cycle after its input transfer.
// Throughput: one item per cycle; the input side stalls only while a finished
// result waits in the output register and out_ready is low.
// Reset (rst_n, asynchronous, active low): levels, counters and pending flags
// clear, confirmation goes idle, debounce_count returns to 3, confirm_delay to 10.
module limit_switch_debounce_confirm (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  lsdc_pkg::lsdc_in_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output lsdc_pkg::lsdc_out_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [lsdc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lsdc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // Configuration registers
    logic [7:0]  debounce_count_reg;
    logic [15:0] confirm_delay_reg;

    // Block state, advanced once per input transfer
    logic                  up_level_reg,   up_level_next;
    logic                  down_level_reg, down_level_next;
    logic [7:0]            up_count_reg,   up_count_next;
    logic [7:0]            down_count_reg, down_count_next;
    logic                  up_flag_reg,    up_flag_next;
    logic                  down_flag_reg,  down_flag_next;
    lsdc_pkg::lsdc_phase_t phase_reg,      phase_next;
    logic [15:0]           elapsed_reg,    elapsed_next;

    // Output register: parts the input side from a stalled consumer
    logic                  out_valid_reg,  out_valid_next;
    lsdc_pkg::lsdc_out_t   out_data_reg,   out_data_next;

    logic                  in_xfer;
    lsdc_pkg::lsdc_deb_t   up_deb;
    lsdc_pkg::lsdc_deb_t   down_deb;

    // One debounce step: count samples that differ from the held level,
    // flip the level once the count reaches the limit.
    function automatic lsdc_pkg::lsdc_deb_t debounce_step(
        input logic       raw,
        input logic       level,
        input logic [7:0] count,
        input logic [7:0] limit
    );
        lsdc_pkg::lsdc_deb_t res;
        logic [7:0]          cnt_inc;
        cnt_inc   = (count != 8'hFF) ? count + 8'd1 : count;
        res.level = level;
        res.count = 8'd0;
        res.rise  = 1'b0;
        if (raw != level)
        begin
            if (cnt_inc >= limit)
            begin
                res.level = raw;
                res.rise  = raw;
            end
            else
            begin
                res.count = cnt_inc;
            end
        end
        return res;
    endfunction

    // Accept a new item whenever the output register is empty or drains now
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign up_deb   = debounce_step(in_data.up_raw, up_level_reg, up_count_reg,
                                    debounce_count_reg);
    assign down_deb = debounce_step(in_data.down_raw, down_level_reg, down_count_reg,
                                    debounce_count_reg);

    // Next state for one item: timer first, then debounce triggers, then clear
    always_comb
    begin
        up_flag_next    = up_flag_reg;
        down_flag_next  = down_flag_reg;
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        up_level_next   = up_level_reg;
        down_level_next = down_level_reg;
        up_count_next   = up_count_reg;
        down_count_next = down_count_reg;

        // Advance the confirmation timer from the held phase
        unique case (phase_reg)
            lsdc_pkg::PHASE_IDLE:
            begin
            end
            lsdc_pkg::PHASE_WAIT:
            begin
                if (in_data.tick_strobe && (elapsed_reg != 16'hFFFF))
                begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
                if (elapsed_next >= confirm_delay_reg)
                begin
                    phase_next = lsdc_pkg::PHASE_DONE;
                end
            end
            default:
            begin
                // Confirmed (or the unused code): drop flags, back to idle
                up_flag_next   = 1'b0;
                down_flag_next = 1'b0;
                phase_next     = lsdc_pkg::PHASE_IDLE;
                elapsed_next   = 16'd0;
            end
        endcase

        // Debounce on a sample strobe; a rising level restarts the wait
        if (in_data.sample_strobe)
        begin
            up_level_next   = up_deb.level;
            up_count_next   = up_deb.count;
            down_level_next = down_deb.level;
            down_count_next = down_deb.count;
            if (up_deb.rise)
            begin
                up_flag_next = 1'b1;
                phase_next   = lsdc_pkg::PHASE_WAIT;
                elapsed_next = 16'd0;
            end
            if (down_deb.rise)
            begin
                down_flag_next = 1'b1;
                phase_next     = lsdc_pkg::PHASE_WAIT;
                elapsed_next   = 16'd0;
            end
        end

        // Clear wins over any trigger; levels and counters still update
        if (in_data.clear_confirm)
        begin
            up_flag_next   = 1'b0;
            down_flag_next = 1'b0;
            phase_next     = lsdc_pkg::PHASE_IDLE;
            elapsed_next   = 16'd0;
        end
    end

    // Result fields are the state after the step
    always_comb
    begin
        out_data_next.up_level      = up_level_next;
        out_data_next.down_level    = down_level_next;
        out_data_next.up_pending    = up_flag_next;
        out_data_next.down_pending  = down_flag_next;
        out_data_next.confirm_phase = phase_next;
        out_data_next.confirm_busy  = (phase_next != lsdc_pkg::PHASE_IDLE);
    end

    // Hold the result until it transfers; load a new one on every input transfer
    always_comb
    begin
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg <= lsdc_pkg::DEBOUNCE_COUNT_RESET;
            confirm_delay_reg  <= lsdc_pkg::CONFIRM_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsdc_pkg::CFG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_data[7:0];
                lsdc_pkg::CFG_CONFIRM_DELAY:  confirm_delay_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_level_reg   <= 1'b0;
            down_level_reg <= 1'b0;
            up_count_reg   <= 8'd0;
            down_count_reg <= 8'd0;
            up_flag_reg    <= 1'b0;
            down_flag_reg  <= 1'b0;
            phase_reg      <= lsdc_pkg::PHASE_IDLE;
            elapsed_reg    <= 16'd0;
        end
        else if (in_xfer)
        begin
            up_level_reg   <= up_level_next;
            down_level_reg <= down_level_next;
            up_count_reg   <= up_count_next;
            down_count_reg <= down_count_next;
            up_flag_reg    <= up_flag_next;
            down_flag_reg  <= down_flag_next;
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/lsdc_checker.sv @@
module lsdc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input lsdc_pkg::lsdc_in_t                in_data,
    input logic                              out_valid,
    input logic                              out_ready,
    input lsdc_pkg::lsdc_out_t               out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Every input transfer yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // Busy tracks the phase, and the unused phase code never shows
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_data.confirm_busy == (out_data.confirm_phase != lsdc_pkg::PHASE_IDLE))
            && (out_data.confirm_phase <= lsdc_pkg::PHASE_DONE))
        else $error("confirm_busy or confirm_phase inconsistent");

    // A clear drops everything pending
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.clear_confirm |=>
            !out_data.up_pending && !out_data.down_pending
            && (out_data.confirm_phase == lsdc_pkg::PHASE_IDLE))
        else $error("clear did not drop pending state");

    // Waiting or confirmed only with some switch pending
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.confirm_busy |->
            out_data.up_pending || out_data.down_pending)
        else $error("confirmation busy with nothing pending");

endmodule

bind limit_switch_debounce_confirm lsdc_checker u_lsdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/sv/tb_limit_switch_debounce_confirm.sv @@
module tb_limit_switch_debounce_confirm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 4;
    // Longest legal quiet stretch is set by the receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    lsdc_pkg::lsdc_in_t               in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    lsdc_pkg::lsdc_out_t              out_data;
    logic                             cfg_we    = 1'b0;
    logic [lsdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lsdc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Traffic shaping, set per test phase
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit hold_off_req  = 1'b0;

    int mismatches     = 0;
    int stalled_cycles = 0;

    // Expected switch status, one entry per accepted transfer
    lsdc_pkg::lsdc_out_t expected_status_q[$];

    // Shadow of the block's settings and state
    bit [7:0]              debounce_limit;
    bit [15:0]             confirm_limit;
    bit                    up_level_q;
    bit                    down_level_q;
    bit [7:0]              up_run;
    bit [7:0]              down_run;
    bit                    up_pend_q;
    bit                    down_pend_q;
    lsdc_pkg::lsdc_phase_t confirm_state;
    bit [15:0]             tick_total;

    limit_switch_debounce_confirm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Status predictor
    // ------------------------------------------------------------------

    // Advance one switch's debounce counter; return 1 on a rising level.
    function automatic bit settle_switch(input bit raw, inout bit level, inout bit [7:0] run);
        if (raw != level)
        begin
            // saturate rather than wrap
            if (run != 8'hFF)
                run = run + 8'd1;
            if (run >= debounce_limit)
            begin
                level = raw;
                run   = '0;
                return raw;
            end
        end
        else
        begin
            run = '0;
        end
        return 1'b0;
    endfunction

    function automatic void drop_confirmation();
        up_pend_q     = 1'b0;
        down_pend_q   = 1'b0;
        confirm_state = lsdc_pkg::PHASE_IDLE;
        tick_total    = '0;
    endfunction

    function automatic lsdc_pkg::lsdc_out_t predict_switch_status(
        input lsdc_pkg::lsdc_in_t item
    );
        lsdc_pkg::lsdc_out_t status;
        // Timer moves first, from the state held before this transfer.
        if (confirm_state == lsdc_pkg::PHASE_WAIT)
        begin
            if (item.tick_strobe && tick_total != 16'hFFFF)
                tick_total = tick_total + 16'd1;
            if (tick_total >= confirm_limit)
                confirm_state = lsdc_pkg::PHASE_DONE;
        end
        else if (confirm_state != lsdc_pkg::PHASE_IDLE)
        begin
            drop_confirmation();
        end
        // Then debounce; a rise restarts the wait even out of confirmed.
        if (item.sample_strobe)
        begin
            if (settle_switch(item.up_raw, up_level_q, up_run))
            begin
                up_pend_q     = 1'b1;
                confirm_state = lsdc_pkg::PHASE_WAIT;
                tick_total    = '0;
            end
            if (settle_switch(item.down_raw, down_level_q, down_run))
            begin
                down_pend_q   = 1'b1;
                confirm_state = lsdc_pkg::PHASE_WAIT;
                tick_total    = '0;
            end
        end
        // Clear wins over a same-cycle trigger, levels keep their update.
        if (item.clear_confirm)
            drop_confirmation();
        status.up_level      = up_level_q;
        status.down_level    = down_level_q;
        status.up_pending    = up_pend_q;
        status.down_pending  = down_pend_q;
        status.confirm_phase = confirm_state;
        status.confirm_busy  = (confirm_state != lsdc_pkg::PHASE_IDLE);
        return status;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic lsdc_pkg::lsdc_in_t make_item(bit up, bit down, bit sample, bit tick,
                                                     bit clr);
        lsdc_pkg::lsdc_in_t item;
        item.up_raw        = up;
        item.down_raw      = down;
        item.sample_strobe = sample;
        item.tick_strobe   = tick;
        item.clear_confirm = clr;
        return item;
    endfunction

    // Offer one item, hold it until the transfer, then record its prediction.
    // Valid stays high on return so back-to-back items need no gap.
    task automatic send_item(input lsdc_pkg::lsdc_in_t item);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        expected_status_q.push_back(predict_switch_status(item));
    endtask

    task automatic wait_drained();
        while (expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back once the block has gone quiet.
    task automatic write_settings(input bit [7:0] debounce, input bit [15:0] delay);
        logic [lsdc_pkg::CFG_DATA_W-1:0] debounce_word;
        debounce_word = {8'($urandom), debounce};   // upper bits are ignored
        in_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= lsdc_pkg::CFG_DEBOUNCE_COUNT;
        cfg_data  <= debounce_word;
        @(posedge clk);
        cfg_index <= lsdc_pkg::CFG_CONFIRM_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_we <= 1'b0;
        debounce_limit = debounce;
        confirm_limit  = delay;
    endtask

    // Mostly held raw levels long enough to settle, some short bouncing noise.
    task automatic drive_switch_runs(input int n_items);
        int  sent;
        int  run_len;
        int  settle_len;
        bit  clean;
        bit  up_hold;
        bit  down_hold;
        lsdc_pkg::lsdc_in_t item;
        sent = 0;
        while (sent < n_items)
        begin
            settle_len = (debounce_limit == 0) ? 1 : int'(debounce_limit);
            clean      = ($urandom_range(99) < 75);
            up_hold    = 1'($urandom_range(1));
            down_hold  = 1'($urandom_range(1));
            if (clean)
                run_len = settle_len + int'($urandom_range(0, 3));
            else
                run_len = int'($urandom_range(1, (settle_len > 12) ? 12 : settle_len + 1));
            for (int k = 0; k < run_len && sent < n_items; k++)
            begin
                if (clean)
                begin
                    item = make_item(up_hold, down_hold, $urandom_range(99) < 90,
                                     $urandom_range(99) < 60, $urandom_range(99) < 3);
                end
                else
                begin
                    item = make_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)), 1'($urandom_range(1)),
                                     $urandom_range(99) < 10);
                end
                send_item(item);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------

    // Drop ready at random; on request hold it low for a long stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        lsdc_pkg::lsdc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = expected_status_q.pop_front();
                check_field("up_level", int'(want.up_level), int'(out_data.up_level));
                check_field("down_level", int'(want.down_level), int'(out_data.down_level));
                check_field("up_pending", int'(want.up_pending), int'(out_data.up_pending));
                check_field("down_pending", int'(want.down_pending),
                            int'(out_data.down_pending));
                check_field("confirm_phase", int'(want.confirm_phase),
                            int'(out_data.confirm_phase));
                check_field("confirm_busy", int'(want.confirm_busy),
                            int'(out_data.confirm_busy));
            end
        end
    end

    // Watchdog: end the run if no transfer moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        // Reset settings: three samples to settle, ten ticks to confirm.
        send_item(make_item(0, 0, 0, 0, 0));
        repeat (3) send_item(make_item(1, 0, 1, 0, 0));
        // clear while down is part way through settling
        send_item(make_item(1, 1, 1, 1, 1));

        write_settings(8'd1, 16'd1);
        send_item(make_item(1, 1, 1, 0, 0));   // down rises, wait starts
        send_item(make_item(1, 1, 0, 1, 0));   // one tick confirms
        send_item(make_item(1, 1, 0, 0, 0));   // back to idle, pending drops
        send_item(make_item(0, 0, 1, 0, 0));   // both fall
        send_item(make_item(0, 1, 1, 1, 0));
        send_item(make_item(0, 1, 0, 1, 0));
        // up trigger lands on the confirmed cycle and starts a fresh wait
        send_item(make_item(1, 1, 1, 0, 0));
        send_item(make_item(1, 1, 0, 0, 1));

        // Zero settings: one sample changes a level, wait confirms at once.
        write_settings(8'd0, 16'd0);
        send_item(make_item(0, 1, 1, 0, 0));
        send_item(make_item(1, 1, 1, 0, 0));
        send_item(make_item(1, 1, 0, 0, 0));
        send_item(make_item(1, 1, 0, 0, 0));
        send_item(make_item(0, 0, 1, 0, 0));
        send_item(make_item(1, 1, 1, 1, 1));   // clear beats both triggers
    endtask

    task automatic test_random_phase(input int n_items, input bit [7:0] debounce,
                                     input bit [15:0] delay, input int tx_pct,
                                     input int rx_pct);
        write_settings(debounce, delay);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        drive_switch_runs(n_items);
    endtask

    task automatic test_backpressure();
        write_settings(8'd1, 16'd2);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // Receiver holds off while items keep coming; the input must stall.
        hold_off_req = 1'b1;
        drive_switch_runs(40);
        // Pause the sender until every result is back.
        in_valid <= 1'b0;
        wait_drained();
        drive_switch_runs(40);
    endtask

    initial
    begin
        debounce_limit = lsdc_pkg::DEBOUNCE_COUNT_RESET;
        confirm_limit  = lsdc_pkg::CONFIRM_DELAY_RESET;
        up_level_q     = 1'b0;
        down_level_q   = 1'b0;
        up_run         = '0;
        down_run       = '0;
        drop_confirmation();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(250, lsdc_pkg::DEBOUNCE_COUNT_RESET, lsdc_pkg::CONFIRM_DELAY_RESET,
                          0, 0);
        test_random_phase(250, 8'd1, 16'd1, 67, 0);
        test_random_phase(250, 8'd2, 16'd3, 0, 67);
        test_random_phase(700, 8'd255, 16'd4, 30, 30);
        test_random_phase(150, 8'd4, 16'hFFFF, 0, 0);
        test_random_phase(250, 8'($urandom_range(1, 8)), 16'($urandom_range(1, 30)), 30, 30);
        test_backpressure();

        // Drain, then let the output side settle before the verdict.
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/lsdc_pkg.sv
sv/limit_switch_debounce_confirm.sv
sv/lsdc_checker.sv
tb/sv/tb_limit_switch_debounce_confirm.sv
